@@ rtl/iuhc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iuhc_pkg
// Shared constants and types of the IPv4/UDP receive header checker.
// ----------------------------------------------------------------------------
package iuhc_pkg;

	localparam int COUNTER_WIDTH_DEF = 16;

	// byte positions within the frame header
	localparam logic [5:0] POS_VHL       = 6'd14;
	localparam logic [5:0] POS_TLEN_HI   = 6'd16;
	localparam logic [5:0] POS_TLEN_LO   = 6'd17;
	localparam logic [5:0] POS_FRAG_HI   = 6'd20;
	localparam logic [5:0] POS_FRAG_LO   = 6'd21;
	localparam logic [5:0] POS_PROTO     = 6'd23;
	localparam logic [5:0] POS_DST_FIRST = 6'd30;
	localparam logic [5:0] POS_HDR_END   = 6'd33;
	localparam logic [5:0] POS_IDLE      = 6'd34;

	localparam logic [7:0]  VHL_IPV4   = 8'h45;
	localparam logic [7:0]  FRAG_MASK  = 8'h3f;
	localparam logic [7:0]  PROTO_UDP  = 8'd17;
	localparam logic [16:0] ETH_LEN    = 17'd14;
	localparam logic [16:0] MIN_FRAME  = 17'd60;
	localparam logic [15:0] CSUM_ONES  = 16'hffff;
	localparam logic [31:0] BCAST_ADDR = 32'hffff_ffff;

	// error mask bit positions
	localparam int ERR_W     = 6;
	localparam int ERR_VHL   = 0;
	localparam int ERR_LEN   = 1;
	localparam int ERR_FRAG  = 2;
	localparam int ERR_PROTO = 3;
	localparam int ERR_ADDR  = 4;
	localparam int ERR_CSUM  = 5;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// register map
	localparam int          PADDR_W      = 3;
	localparam logic [0:0]  REG_LOCAL_IP = 1'b0;

	// one header summary from the front part
	typedef struct packed {
		logic [15:0] csum;
		logic [15:0] tlen;
		logic        vhl_err;
		logic        frag_err;
		logic        proto_err;
		logic [31:0] dst;
		logic [15:0] rx_len;
	} entry_t;

	typedef struct packed {
		logic   push;
		entry_t data;
	} q_wr_t;

	typedef struct packed {
		logic   avail;
		entry_t data;
	} q_rd_t;

endpackage
`default_nettype wire

@@ rtl/iuhc_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iuhc_hdr_if, iuhc_res_if
// Valid/ready channels for header bytes in and verdict items out.
// ----------------------------------------------------------------------------
interface iuhc_hdr_if;
	logic        valid;
	logic        ready;
	logic [7:0]  frame_byte;
	logic        start_of_frame;
	logic [15:0] rx_frame_length;

	modport source (output valid, frame_byte, start_of_frame, rx_frame_length, input ready);
	modport sink   (input valid, frame_byte, start_of_frame, rx_frame_length, output ready);
endinterface

interface iuhc_res_if;
	logic        valid;
	logic        ready;
	logic        packet_ok;
	logic [5:0]  error_mask;
	logic [15:0] frame_length;
	logic [15:0] drop_count;
	logic [15:0] vhl_error_count;
	logic [15:0] fragment_error_count;
	logic [15:0] protocol_error_count;
	logic [15:0] checksum_error_count;

	modport source (
		output valid, packet_ok, error_mask, frame_length, drop_count, vhl_error_count,
			fragment_error_count, protocol_error_count, checksum_error_count,
		input ready
	);
	modport sink (
		input valid, packet_ok, error_mask, frame_length, drop_count, vhl_error_count,
			fragment_error_count, protocol_error_count, checksum_error_count,
		output ready
	);
endinterface
`default_nettype wire

@@ rtl/iuhc_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iuhc_front
// Byte parser: tracks header position, folds the checksum, collects fields
// and pushes one summary per header into the queue.
// ----------------------------------------------------------------------------
module iuhc_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	iuhc_hdr_if.sink            hdr,
	output iuhc_pkg::q_wr_t     q_wr,
	input  wire logic           q_full
);
	import iuhc_pkg::*;

	logic [5:0]  pos_q;
	logic [15:0] csum_q;
	logic [7:0]  hold_q;
	logic [15:0] tlen_q;
	logic        vhl_q;
	logic        frag_q;
	logic        proto_q;
	logic [31:0] dst_q;

	logic        accept;
	logic        active;
	logic [16:0] sum;
	logic [15:0] csum_next;
	logic        vhl_next;
	logic        frag_next;
	logic        proto_next;
	logic [31:0] dst_next;
	logic [7:0]  b;

	assign hdr.ready = !q_full;
	assign accept    = hdr.valid && hdr.ready;
	assign b         = hdr.frame_byte;
	assign active    = (pos_q >= POS_VHL) && (pos_q < POS_IDLE);

	// ones-complement add with end-around carry
	assign sum = {1'b0, csum_q} + {1'b0, hold_q, b};
	always_comb begin
		csum_next = csum_q;
		if (active && pos_q[0]) begin
			csum_next = sum[16] ? (sum[15:0] + 16'd1) : sum[15:0];
		end
	end

	always_comb begin
		vhl_next   = vhl_q;
		frag_next  = frag_q;
		proto_next = proto_q;
		dst_next   = dst_q;
		if (pos_q == POS_VHL && b != VHL_IPV4) begin
			vhl_next = 1'b1;
		end
		if (pos_q == POS_FRAG_HI && (b & FRAG_MASK) != 8'd0) begin
			frag_next = 1'b1;
		end
		if (pos_q == POS_FRAG_LO && b != 8'd0) begin
			frag_next = 1'b1;
		end
		if (pos_q == POS_PROTO && b != PROTO_UDP) begin
			proto_next = 1'b1;
		end
		if (pos_q >= POS_DST_FIRST && pos_q < POS_IDLE) begin
			dst_next = {dst_q[23:0], b};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			csum_q  <= '0;
			hold_q  <= '0;
			tlen_q  <= '0;
			vhl_q   <= 1'b0;
			frag_q  <= 1'b0;
			proto_q <= 1'b0;
			dst_q   <= '0;
		end else if (accept) begin
			if (hdr.start_of_frame) begin
				// byte 0 is ethernet, so only the position moves on
				pos_q   <= 6'd1;
				csum_q  <= '0;
				hold_q  <= '0;
				tlen_q  <= '0;
				vhl_q   <= 1'b0;
				frag_q  <= 1'b0;
				proto_q <= 1'b0;
				dst_q   <= '0;
			end else if (pos_q < POS_IDLE) begin
				pos_q   <= (pos_q == POS_HDR_END) ? POS_IDLE : pos_q + 6'd1;
				csum_q  <= csum_next;
				vhl_q   <= vhl_next;
				frag_q  <= frag_next;
				proto_q <= proto_next;
				dst_q   <= dst_next;
				if (active && !pos_q[0]) begin
					hold_q <= b;
				end
				if (pos_q == POS_TLEN_HI) begin
					tlen_q <= {b, 8'd0};
				end
				if (pos_q == POS_TLEN_LO) begin
					tlen_q <= {tlen_q[15:8], b};
				end
			end
		end
	end

	always_comb begin
		q_wr.push           = accept && !hdr.start_of_frame && (pos_q == POS_HDR_END);
		q_wr.data.csum      = csum_next;
		q_wr.data.tlen      = tlen_q;
		q_wr.data.vhl_err   = vhl_next;
		q_wr.data.frag_err  = frag_next;
		q_wr.data.proto_err = proto_next;
		q_wr.data.dst       = dst_next;
		q_wr.data.rx_len    = hdr.rx_frame_length;
	end

`ifndef ASSERT_OFF
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_IDLE)
		else $error("header position out of range");
`endif

endmodule
`default_nettype wire

@@ rtl/iuhc_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iuhc_queue
// Short register queue of header summaries between front and back parts.
// ----------------------------------------------------------------------------
module iuhc_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire iuhc_pkg::q_wr_t q_wr,
	output logic                q_full,
	output iuhc_pkg::q_rd_t     q_rd,
	input  wire logic           pop
);
	import iuhc_pkg::*;

	entry_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                empty;

	assign q_full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty      = (count_q == '0);
	assign q_rd.avail = !empty;
	assign q_rd.data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (q_wr.push) begin
			mem_q[wr_ptr_q] <= q_wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (q_wr.push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (q_wr.push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !q_wr.push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr.push |-> !q_full)
		else $error("push into full queue");
`endif
`ifndef ASSERT_OFF
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

@@ rtl/iuhc_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iuhc_back
// Verdict stage: final length, address and checksum checks, error counters
// and the output register.
// ----------------------------------------------------------------------------
module iuhc_back #(
	parameter int COUNTER_WIDTH = iuhc_pkg::COUNTER_WIDTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire iuhc_pkg::q_rd_t q_rd,
	output logic                pop,
	input  wire logic [31:0]    local_ip,
	iuhc_res_if.source          res
);
	import iuhc_pkg::*;

	localparam int CW = COUNTER_WIDTH;

	logic [CW-1:0]    drop_q;
	logic [CW-1:0]    vhl_cnt_q;
	logic [CW-1:0]    frag_cnt_q;
	logic [CW-1:0]    proto_cnt_q;
	logic [CW-1:0]    csum_cnt_q;
	logic             valid_q;
	logic             ok_q;
	logic [ERR_W-1:0] mask_q;
	logic [15:0]      flen_q;

	entry_t           e;
	logic [16:0]      real_len;
	logic [ERR_W-1:0] f;
	logic [2:0]       n;
	logic [15:0]      flen;
	logic [CW-1:0]    one;

	assign e        = q_rd.data;
	assign pop      = q_rd.avail && (!valid_q || res.ready);
	assign real_len = {1'b0, e.tlen} + ETH_LEN;
	assign one      = {{(CW-1){1'b0}}, 1'b1};

	always_comb begin
		f            = '0;
		f[ERR_VHL]   = e.vhl_err;
		f[ERR_LEN]   = real_len > {1'b0, e.rx_len};
		f[ERR_FRAG]  = e.frag_err;
		f[ERR_PROTO] = e.proto_err;
		f[ERR_ADDR]  = (e.dst != BCAST_ADDR) && (e.dst != local_ip);
		f[ERR_CSUM]  = (e.csum != CSUM_ONES) && (e.csum != 16'd0);
		n            = 3'($countones(f));
		// padded minimum-size frame carrying a shorter packet
		flen = ((real_len < MIN_FRAME) && ({1'b0, e.rx_len} == MIN_FRAME)) ?
			real_len[15:0] : e.rx_len;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			drop_q      <= '0;
			vhl_cnt_q   <= '0;
			frag_cnt_q  <= '0;
			proto_cnt_q <= '0;
			csum_cnt_q  <= '0;
		end else begin
			if (pop) begin
				valid_q <= 1'b1;
				drop_q  <= drop_q + {{(CW-3){1'b0}}, n};
				if (f[ERR_VHL]) begin
					vhl_cnt_q <= vhl_cnt_q + one;
				end
				if (f[ERR_FRAG]) begin
					frag_cnt_q <= frag_cnt_q + one;
				end
				if (f[ERR_PROTO]) begin
					proto_cnt_q <= proto_cnt_q + one;
				end
				if (f[ERR_CSUM]) begin
					csum_cnt_q <= csum_cnt_q + one;
				end
			end else if (res.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ok_q   <= (f == '0);
			mask_q <= f;
			flen_q <= flen;
		end
	end

	assign res.valid        = valid_q;
	assign res.packet_ok    = ok_q;
	assign res.error_mask   = mask_q;
	assign res.frame_length = flen_q;

	// counters only change when a verdict is loaded, so they feed the port directly
	generate
		if (CW >= 16) begin : g_cnt_trunc
			assign res.drop_count           = drop_q[15:0];
			assign res.vhl_error_count      = vhl_cnt_q[15:0];
			assign res.fragment_error_count = frag_cnt_q[15:0];
			assign res.protocol_error_count = proto_cnt_q[15:0];
			assign res.checksum_error_count = csum_cnt_q[15:0];
		end else begin : g_cnt_ext
			assign res.drop_count           = {{(16-CW){1'b0}}, drop_q};
			assign res.vhl_error_count      = {{(16-CW){1'b0}}, vhl_cnt_q};
			assign res.fragment_error_count = {{(16-CW){1'b0}}, frag_cnt_q};
			assign res.protocol_error_count = {{(16-CW){1'b0}}, proto_cnt_q};
			assign res.checksum_error_count = {{(16-CW){1'b0}}, csum_cnt_q};
		end
	endgenerate

`ifndef ASSERT_OFF
	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!pop |=> $stable(drop_q) && $stable(csum_cnt_q))
		else $error("counter moved without a verdict");
`endif

endmodule
`default_nettype wire

@@ rtl/ipv4_udp_rx_header_check_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_udp_rx_header_check_core
// IPv4/UDP receive header checker with error counters and APB register port.
// ----------------------------------------------------------------------------
// Takes the 34 header bytes of a received frame, one byte per cycle with no
// gaps needed, and gives one verdict item for byte 33: pass flag, error mask,
// corrected frame length and the wrapping error counters. The front parser
// handles one byte per cycle; the verdict is queued when byte 33 is accepted
// and then loaded into the output register. Up to four verdicts queue ahead of
// the output register, and bytes are refused only while that queue is full.
// local_ip_address sits at byte address 0 of the APB port.
module ipv4_udp_rx_header_check_core #(
	parameter int COUNTER_WIDTH = iuhc_pkg::COUNTER_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	iuhc_hdr_if.sink                           hdr,
	iuhc_res_if.source                         res,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [iuhc_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready
);
	import iuhc_pkg::*;

	logic [31:0] local_ip_q;
	q_wr_t       q_wr;
	q_rd_t       q_rd;
	logic        q_full;
	logic        pop;
	logic        reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_LOCAL_IP);
	assign prdata  = reg_sel ? local_ip_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_ip_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			local_ip_q <= pwdata;
		end
	end

	iuhc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.hdr    (hdr),
		.q_wr   (q_wr),
		.q_full (q_full)
	);

	iuhc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.q_full (q_full),
		.q_rd   (q_rd),
		.pop    (pop)
	);

	iuhc_back #(
		.COUNTER_WIDTH (COUNTER_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_rd     (q_rd),
		.pop      (pop),
		.local_ip (local_ip_q),
		.res      (res)
	);

endmodule
`default_nettype wire

@@ sim/iuhc_verdict_checker.sv @@
// ----------------------------------------------------------------------------
// iuhc_verdict_checker
// Watches the header byte, verdict and register channels of the header
// checker. It keeps its own model of the parser state and error counters,
// queues the verdict due for every byte 33 taken in, and compares each
// verdict leaving the block against the oldest one queued.
// ----------------------------------------------------------------------------
module iuhc_verdict_checker (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	iuhc_hdr_if                               hdr,
	iuhc_res_if                               res,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic                         pready,
	input  wire logic [iuhc_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                  pwdata,
	output int                                fail_count,
	output int                                pending,
	output int                                verdicts_seen,
	output int                                passes_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import iuhc_pkg::*;

	localparam logic [PADDR_W-1:0] LOCAL_IP_ADDR = PADDR_W'(4 * REG_LOCAL_IP);
	localparam int                 REPORT_MAX    = 10;

	typedef struct packed {
		logic        packet_ok;
		logic [5:0]  error_mask;
		logic [15:0] frame_length;
		logic [15:0] drop_count;
		logic [15:0] vhl_count;
		logic [15:0] frag_count;
		logic [15:0] proto_count;
		logic [15:0] csum_count;
	} verdict_t;

	verdict_t expected_verdicts[$];

	logic [31:0] local_ip;
	logic [5:0]  hdr_pos;
	logic [15:0] csum_acc;
	logic [7:0]  hi_hold;
	logic [15:0] ip_tlen;
	logic [5:0]  err_flags;
	logic [31:0] dst_addr;
	logic [15:0] drop_cnt;
	logic [15:0] vhl_cnt;
	logic [15:0] frag_cnt;
	logic [15:0] proto_cnt;
	logic [15:0] csum_cnt;
	int          mismatches;
	int          n_verdicts;
	int          n_passes;

	task automatic clear_frame();
		hdr_pos   = '0;
		csum_acc  = '0;
		hi_hold   = '0;
		ip_tlen   = '0;
		err_flags = '0;
		dst_addr  = '0;
	endtask

	task automatic predict_byte(input logic [7:0] b, input logic sof, input logic [15:0] rx,
			output logic got, output verdict_t v);
		logic [16:0] sum;
		logic [16:0] real_len;
		logic [5:0]  f;
		logic [15:0] flen;
		got = 1'b0;
		v   = '0;
		if (sof)
			clear_frame();
		if (hdr_pos < POS_IDLE) begin
			if (hdr_pos >= POS_VHL) begin
				// header words start on an even position
				if (!hdr_pos[0]) begin
					hi_hold = b;
				end else begin
					sum      = {1'b0, csum_acc} + {1'b0, hi_hold, b};
					csum_acc = sum[15:0] + 16'(sum[16]);
				end
				if (hdr_pos == POS_VHL && b != VHL_IPV4)
					err_flags[ERR_VHL] = 1'b1;
				if (hdr_pos == POS_TLEN_HI)
					ip_tlen = {b, 8'h00};
				if (hdr_pos == POS_TLEN_LO)
					ip_tlen[7:0] = b;
				if (hdr_pos == POS_FRAG_HI && (b & FRAG_MASK) != 0)
					err_flags[ERR_FRAG] = 1'b1;
				if (hdr_pos == POS_FRAG_LO && b != 0)
					err_flags[ERR_FRAG] = 1'b1;
				if (hdr_pos == POS_PROTO && b != PROTO_UDP)
					err_flags[ERR_PROTO] = 1'b1;
				if (hdr_pos >= POS_DST_FIRST)
					dst_addr = {dst_addr[23:0], b};
			end
			if (hdr_pos != POS_HDR_END) begin
				hdr_pos = hdr_pos + 6'd1;
			end else begin
				real_len = {1'b0, ip_tlen} + ETH_LEN;
				f        = err_flags;
				flen     = rx;
				if (real_len > {1'b0, rx})
					f[ERR_LEN] = 1'b1;
				// padded minimum-size frame carries the true length
				if (real_len < MIN_FRAME && {1'b0, rx} == MIN_FRAME)
					flen = real_len[15:0];
				if (dst_addr != BCAST_ADDR && dst_addr != local_ip)
					f[ERR_ADDR] = 1'b1;
				if (csum_acc != CSUM_ONES && csum_acc != 16'h0000)
					f[ERR_CSUM] = 1'b1;
				drop_cnt = drop_cnt + 16'($countones(f));
				if (f[ERR_VHL])
					vhl_cnt = vhl_cnt + 16'd1;
				if (f[ERR_FRAG])
					frag_cnt = frag_cnt + 16'd1;
				if (f[ERR_PROTO])
					proto_cnt = proto_cnt + 16'd1;
				if (f[ERR_CSUM])
					csum_cnt = csum_cnt + 16'd1;
				err_flags = f;
				hdr_pos   = POS_IDLE;
				v.packet_ok    = (f == '0);
				v.error_mask   = f;
				v.frame_length = flen;
				v.drop_count   = drop_cnt;
				v.vhl_count    = vhl_cnt;
				v.frag_count   = frag_cnt;
				v.proto_count  = proto_cnt;
				v.csum_count   = csum_cnt;
				got = 1'b1;
			end
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] seen);
		if (want !== seen) begin
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("verdict %0d %s: expected %0h, got %0h", n_verdicts, name, want, seen);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic     got;
		verdict_t v;
		if (!arst_n) begin
			clear_frame();
			local_ip   = '0;
			drop_cnt   = '0;
			vhl_cnt    = '0;
			frag_cnt   = '0;
			proto_cnt  = '0;
			csum_cnt   = '0;
			mismatches = 0;
			n_verdicts = 0;
			n_passes   = 0;
			expected_verdicts.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr == LOCAL_IP_ADDR)
				local_ip = pwdata;
			if (hdr.valid && hdr.ready) begin
				predict_byte(hdr.frame_byte, hdr.start_of_frame, hdr.rx_frame_length, got, v);
				if (got)
					expected_verdicts.push_back(v);
			end
			if (res.valid && res.ready) begin
				if (expected_verdicts.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("verdict with none expected: mask %0h", res.error_mask);
				end else begin
					v = expected_verdicts.pop_front();
					check_field("packet_ok", 16'(v.packet_ok), 16'(res.packet_ok));
					check_field("error_mask", 16'(v.error_mask), 16'(res.error_mask));
					check_field("frame_length", v.frame_length, res.frame_length);
					check_field("drop_count", v.drop_count, res.drop_count);
					check_field("vhl_error_count", v.vhl_count, res.vhl_error_count);
					check_field("fragment_error_count", v.frag_count, res.fragment_error_count);
					check_field("protocol_error_count", v.proto_count, res.protocol_error_count);
					check_field("checksum_error_count", v.csum_count, res.checksum_error_count);
				end
				n_verdicts++;
				if (res.packet_ok)
					n_passes++;
			end
		end
		fail_count    <= mismatches;
		pending       <= expected_verdicts.size();
		verdicts_seen <= n_verdicts;
		passes_seen   <= n_passes;
	end

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives header bytes and register writes into the IPv4/UDP header checker.
// A directed run of frames hits each check alone and together, padded and
// overlong lengths, restarts and trailing bytes; random frames follow under
// several local addresses, with random stalls on both channels and one long
// receiver hold-off. Verdicts are checked by a separate checker module.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import iuhc_pkg::*;

	localparam logic [PADDR_W-1:0] LOCAL_IP_ADDR = PADDR_W'(4 * REG_LOCAL_IP);
	localparam int                 HDR_LEN       = 34;
	localparam int                 PHASE_BYTES   = 420;
	localparam int                 HOLD_CYCLES   = 600;
	localparam int                 DRAIN_CYCLES  = 16;
	localparam int                 CYCLE_LIMIT   = 100000;
	localparam logic [5:0]         POS_CSUM_HI   = POS_PROTO + 6'd1;
	localparam logic [5:0]         POS_CSUM_LO   = POS_PROTO + 6'd2;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	iuhc_hdr_if hdr_ch ();
	iuhc_res_if res_ch ();

	int          fail_count;
	int          pending;
	int          verdicts_seen;
	int          passes_seen;
	int          bytes_sent;
	int          cycles;
	int          ip_settings;
	bit          calm;
	bit          hold_req;
	bit          hold_done;
	logic [31:0] cur_ip;
	logic [7:0]  hdr_buf [0:HDR_LEN-1];
	logic [15:0] rx_len_buf;

	ipv4_udp_rx_header_check_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.hdr     (hdr_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	iuhc_verdict_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.hdr           (hdr_ch),
		.res           (res_ch),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.fail_count    (fail_count),
		.pending       (pending),
		.verdicts_seen (verdicts_seen),
		.passes_seen   (passes_seen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("run stopped at the cycle limit with %0d verdicts pending", pending);
			$display("TB_ERROR");
			$finish;
		end
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		res_ch.ready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				res_ch.ready <= 1'b0;
				hold_done = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				res_ch.ready <= calm || ($urandom_range(99) >= 23);
			end
		end
	end

	task automatic send_item(input logic [7:0] b, input logic sof, input logic [15:0] rx,
			input bit counted);
		if (!calm && $urandom_range(99) < 23) begin
			hdr_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		hdr_ch.valid           <= 1'b1;
		hdr_ch.frame_byte      <= b;
		hdr_ch.start_of_frame  <= sof;
		hdr_ch.rx_frame_length <= rx;
		@(posedge clk);
		while (!hdr_ch.ready)
			@(posedge clk);
		if (counted)
			bytes_sent++;
	endtask

	// only the last header byte carries the length that counts
	task automatic send_frame(input logic sof_first, input int count, input bit counted);
		for (int i = 0; i < count; i++)
			send_item(hdr_buf[i], (i == 0) ? sof_first : 1'b0,
				(i == int'(POS_HDR_END)) ? rx_len_buf : 16'($urandom), counted);
	endtask

	task automatic seal_checksum();
		logic [16:0] acc;
		hdr_buf[POS_CSUM_HI] = 8'h00;
		hdr_buf[POS_CSUM_LO] = 8'h00;
		acc = '0;
		for (int i = int'(POS_VHL); i <= int'(POS_HDR_END); i += 2) begin
			acc = {1'b0, acc[15:0]} + {1'b0, hdr_buf[i], hdr_buf[i + 1]};
			acc = {1'b0, acc[15:0] + 16'(acc[16])};
		end
		{hdr_buf[POS_CSUM_HI], hdr_buf[POS_CSUM_LO]} = ~acc[15:0];
	endtask

	task automatic fill_good_header(input logic [31:0] dst);
		logic [15:0] tlen;
		logic [16:0] real_len;
		for (int i = 0; i < HDR_LEN; i++)
			hdr_buf[i] = 8'($urandom);
		tlen = ($urandom_range(3) == 0) ? 16'($urandom_range(20, 45))
			: 16'($urandom_range(20, 1500));
		hdr_buf[POS_VHL] = VHL_IPV4;
		{hdr_buf[POS_TLEN_HI], hdr_buf[POS_TLEN_LO]} = tlen;
		hdr_buf[POS_FRAG_HI] = hdr_buf[POS_FRAG_HI] & ~FRAG_MASK;
		hdr_buf[POS_FRAG_LO] = 8'h00;
		hdr_buf[POS_PROTO]   = PROTO_UDP;
		{hdr_buf[POS_DST_FIRST], hdr_buf[POS_DST_FIRST + 6'd1], hdr_buf[POS_DST_FIRST + 6'd2],
			hdr_buf[POS_DST_FIRST + 6'd3]} = dst;
		real_len = {1'b0, tlen} + ETH_LEN;
		if (real_len < MIN_FRAME && $urandom_range(1) == 1)
			rx_len_buf = MIN_FRAME[15:0];
		else
			rx_len_buf = real_len[15:0] + 16'($urandom_range(0, 3));
		seal_checksum();
	endtask

	// break the checks named in the mask, checksum last so the others stay sealed
	task automatic corrupt(input logic [5:0] which);
		logic [16:0] real_len;
		if (which[ERR_VHL])
			hdr_buf[POS_VHL] = VHL_IPV4 ^ 8'($urandom_range(1, 255));
		if (which[ERR_FRAG]) begin
			if ($urandom_range(1) == 1)
				hdr_buf[POS_FRAG_HI] = hdr_buf[POS_FRAG_HI] | 8'(1 << $urandom_range(5));
			else
				hdr_buf[POS_FRAG_LO] = 8'($urandom_range(1, 255));
		end
		if (which[ERR_PROTO])
			hdr_buf[POS_PROTO] = PROTO_UDP ^ 8'($urandom_range(1, 255));
		if (which[ERR_ADDR])
			hdr_buf[POS_DST_FIRST] = hdr_buf[POS_DST_FIRST] ^ 8'($urandom_range(1, 255));
		if (which[ERR_LEN]) begin
			real_len   = {1'b0, hdr_buf[POS_TLEN_HI], hdr_buf[POS_TLEN_LO]} + ETH_LEN;
			rx_len_buf = 16'(real_len - 17'($urandom_range(1, 33)));
		end
		seal_checksum();
		if (which[ERR_CSUM])
			hdr_buf[POS_CSUM_HI] = hdr_buf[POS_CSUM_HI] ^ 8'($urandom_range(1, 255));
	endtask

	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic wait_idle();
		hdr_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_local_ip(input logic [31:0] value);
		wait_idle();
		apb_write(LOCAL_IP_ADDR, value);
		cur_ip = value;
		ip_settings++;
	endtask

	task automatic random_frame();
		int          kind;
		logic [31:0] dst;
		logic [5:0]  errs;
		kind = $urandom_range(99);
		case ($urandom_range(2))
			0: dst = cur_ip;
			1: dst = BCAST_ADDR;
			default: dst = $urandom;
		endcase
		errs = '0;
		for (int e = 0; e < ERR_W; e++)
			errs[e] = ($urandom_range(9) == 0);
		fill_good_header(dst);
		corrupt(errs);
		if (kind < 12) begin
			for (int i = 0; i < HDR_LEN; i++)
				hdr_buf[i] = 8'($urandom);
			rx_len_buf = 16'($urandom);
			send_frame(1'b1, HDR_LEN, 1'b1);
		end else if (kind < 22) begin
			// cut short, the next frame restarts the parser
			send_frame(1'b1, $urandom_range(1, HDR_LEN - 1), 1'b1);
		end else begin
			send_frame(1'b1, HDR_LEN, 1'b1);
			if (kind < 32)
				send_frame(1'b0, $urandom_range(1, 6), 1'b0);
		end
	endtask

	initial begin
		int frames;
		arst_n                 <= 1'b0;
		psel                   <= 1'b0;
		penable                <= 1'b0;
		pwrite                 <= 1'b0;
		paddr                  <= '0;
		pwdata                 <= '0;
		hdr_ch.valid           <= 1'b0;
		hdr_ch.frame_byte      <= '0;
		hdr_ch.start_of_frame  <= 1'b0;
		hdr_ch.rx_frame_length <= '0;
		bytes_sent  = 0;
		ip_settings = 0;
		calm        = 1'b0;
		hold_req    = 1'b0;
		cur_ip      = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_local_ip(32'h0a00_0001);
		// first frame after reset comes without a start mark
		fill_good_header(cur_ip);
		send_frame(1'b0, HDR_LEN, 1'b1);
		fill_good_header(BCAST_ADDR);
		send_frame(1'b1, HDR_LEN, 1'b1);
		for (int e = 0; e < ERR_W; e++) begin
			fill_good_header(cur_ip);
			corrupt(6'(1 << e));
			send_frame(1'b1, HDR_LEN, 1'b1);
		end
		fill_good_header(cur_ip);
		corrupt('1);
		send_frame(1'b1, HDR_LEN, 1'b1);
		// short datagram in a padded minimum frame
		fill_good_header(cur_ip);
		{hdr_buf[POS_TLEN_HI], hdr_buf[POS_TLEN_LO]} = 16'd28;
		rx_len_buf = MIN_FRAME[15:0];
		seal_checksum();
		send_frame(1'b1, HDR_LEN, 1'b1);
		// largest total lengths, sum with the ethernet header must not wrap
		fill_good_header(cur_ip);
		{hdr_buf[POS_TLEN_HI], hdr_buf[POS_TLEN_LO]} = 16'hffff;
		rx_len_buf = 16'hffff;
		seal_checksum();
		send_frame(1'b1, HDR_LEN, 1'b1);
		fill_good_header(cur_ip);
		{hdr_buf[POS_TLEN_HI], hdr_buf[POS_TLEN_LO]} = 16'hfff1;
		rx_len_buf = 16'hffff;
		seal_checksum();
		send_frame(1'b1, HDR_LEN, 1'b1);
		for (int i = 0; i < HDR_LEN; i++)
			hdr_buf[i] = 8'h00;
		rx_len_buf = 16'h0000;
		send_frame(1'b1, HDR_LEN, 1'b1);
		for (int i = 0; i < HDR_LEN; i++)
			hdr_buf[i] = 8'hff;
		rx_len_buf = 16'hffff;
		send_frame(1'b1, HDR_LEN, 1'b1);
		// restart part way through a frame
		fill_good_header(cur_ip);
		send_frame(1'b1, 20, 1'b1);
		fill_good_header(cur_ip);
		send_frame(1'b1, HDR_LEN, 1'b1);
		// bytes after the header are ignored
		send_frame(1'b0, 5, 1'b0);

		for (int ph = 0; ph < 3; ph++) begin
			int phase_end;
			case (ph)
				0: set_local_ip(32'h0000_0000);
				1: set_local_ip(32'hffff_ffff);
				default: set_local_ip($urandom);
			endcase
			phase_end = bytes_sent + PHASE_BYTES;
			frames    = 0;
			while (bytes_sent < phase_end) begin
				calm = (ph == 1 && frames >= 3 && frames < 10);
				if (ph == 2 && frames == 4)
					hold_req = 1'b1;
				random_frame();
				frames++;
			end
			calm = 1'b0;
		end

		wait_idle();
		$display("sent %0d header bytes under %0d local addresses, one %0d-cycle receiver hold-off",
			bytes_sent, ip_settings, HOLD_CYCLES);
		$display("checked %0d verdicts, %0d passing, %0d mismatches",
			verdicts_seen, passes_seen, fail_count);
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
